FILE: hw/rtl/utf8vc_pkg.sv
package utf8vc_pkg;

   // Width of the running code point counter
   localparam int COUNT_WIDTH = 16;
   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = {COUNT_WIDTH{1'b1}};

   // Compare width wide enough for both the counter and the 16-bit result fields
   localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   localparam int BYTE_WIDTH      = 8;
   localparam int CHARS_WIDTH     = 16;
   localparam int CP_WIDTH        = 21;
   localparam int RSP_TDATA_WIDTH = 24;

   localparam logic [CHARS_WIDTH-1:0] MAX_CHARS_RESET = 16'd1024;
   localparam logic [CHARS_WIDTH-1:0] CHAR_COUNT_MAX  = 16'hFFFF;

   // Code point range limits
   localparam logic [CP_WIDTH-1:0] CP_MIN_2BYTE  = 21'h000080;
   localparam logic [CP_WIDTH-1:0] CP_MIN_3BYTE  = 21'h000800;
   localparam logic [CP_WIDTH-1:0] CP_MIN_4BYTE  = 21'h010000;
   localparam logic [CP_WIDTH-1:0] CP_MAX        = 21'h10FFFF;
   localparam logic [CP_WIDTH-1:0] SURROGATE_LO  = 21'h00D800;
   localparam logic [CP_WIDTH-1:0] SURROGATE_HI  = 21'h00DFFF;

   // Lead byte boundaries
   localparam logic [7:0] ASCII_MAX   = 8'h7F;
   localparam logic [7:0] LEAD2_MIN   = 8'hC2;
   localparam logic [7:0] LEAD2_MAX   = 8'hDF;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD3_MAX   = 8'hEF;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD4_MAX   = 8'hF4;
   localparam logic [1:0] CONT_PREFIX = 2'b10;

   // Sequence length classes (number of continuation bytes)
   localparam logic [1:0] CLASS_NONE = 2'd0;
   localparam logic [1:0] CLASS_TWO  = 2'd1;
   localparam logic [1:0] CLASS_THREE = 2'd2;
   localparam logic [1:0] CLASS_FOUR = 2'd3;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_TOO_MANY = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] text_byte;
      logic                  byte_present;
      logic                  end_of_text;
   } item_type;

   typedef struct packed {
      status_type             status;
      logic [CHARS_WIDTH-1:0] char_count;
   } result_type;

endpackage

FILE: hw/rtl/utf8vc_in_stage.sv
module utf8vc_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  utf8vc_pkg::item_type in_item,
   input  logic                advance,
   output logic                item_valid,
   output utf8vc_pkg::item_type item
);
   import utf8vc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   // Take a new item when the stage is empty or its item moves on this cycle
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload unless a new item is taken
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: hw/rtl/utf8vc_core.sv
module utf8vc_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  utf8vc_pkg::item_type                item,
   input  logic [utf8vc_pkg::CHARS_WIDTH-1:0]  max_chars,
   output logic                                result_valid,
   output utf8vc_pkg::result_type              result
);
   import utf8vc_pkg::*;

   logic [1:0]             pend_ff, pend_in;
   logic [CP_WIDTH-1:0]    partial_ff, partial_in;
   logic [1:0]             class_ff, class_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic                   failed_ff, failed_in;

   always_comb begin
      logic [7:0]          b;
      logic [CP_WIDTH-1:0] cp;
      logic [CP_WIDTH-1:0] minimum;
      logic                count_it;
      logic [CMP_WIDTH-1:0] count_wide;
      logic [CMP_WIDTH-1:0] max_wide;

      b          = item.text_byte;
      cp         = '0;
      minimum    = CP_MIN_4BYTE;
      count_it   = 1'b0;
      count_wide = '0;
      max_wide   = '0;

      pend_in    = pend_ff;
      partial_in = partial_ff;
      class_in   = class_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      failed_in  = failed_ff;

      // Decode one byte against the open sequence
      if (item.byte_present && !failed_ff) begin
         if (pend_ff == 2'd0) begin
            if (b <= ASCII_MAX) begin
               count_it = 1'b1;
            end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
               pend_in    = 2'd1;
               class_in   = CLASS_TWO;
               partial_in = {16'd0, b[4:0]};
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
               pend_in    = 2'd2;
               class_in   = CLASS_THREE;
               partial_in = {17'd0, b[3:0]};
            end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
               pend_in    = 2'd3;
               class_in   = CLASS_FOUR;
               partial_in = {18'd0, b[2:0]};
            end else begin
               failed_in = 1'b1;
            end
         end else if (b[7:6] != CONT_PREFIX) begin
            failed_in = 1'b1;
         end else begin
            cp         = {partial_ff[CP_WIDTH-7:0], b[5:0]};
            partial_in = cp;
            pend_in    = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               // Sequence complete: reject overlong, out of range and surrogates
               case (class_ff)
                  CLASS_TWO:   minimum = CP_MIN_2BYTE;
                  CLASS_THREE: minimum = CP_MIN_3BYTE;
                  default:     minimum = CP_MIN_4BYTE;
               endcase
               if (cp < minimum || cp > CP_MAX ||
                   (cp >= SURROGATE_LO && cp <= SURROGATE_HI)) begin
                  failed_in = 1'b1;
               end else begin
                  count_it = 1'b1;
               end
               partial_in = '0;
               class_in   = CLASS_NONE;
            end
         end
      end

      // Saturating count
      if (count_it) begin
         if (count_ff == COUNT_LIMIT) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end

      // Build the result from the state after this byte
      count_wide = CMP_WIDTH'(count_in);
      max_wide   = CMP_WIDTH'(max_chars);
      result_valid = fire && item.end_of_text;
      if (failed_in || pend_in != 2'd0) begin
         result.status     = ST_INVALID;
         result.char_count = '0;
      end else if (count_in == '0 && !ovf_in) begin
         result.status     = ST_EMPTY;
         result.char_count = '0;
      end else begin
         result.status = (ovf_in || count_wide > max_wide) ? ST_TOO_MANY : ST_OK;
         if (count_wide > CMP_WIDTH'(CHAR_COUNT_MAX)) begin
            result.char_count = CHAR_COUNT_MAX;
         end else begin
            result.char_count = count_wide[CHARS_WIDTH-1:0];
         end
      end

      // Clear for the next text
      if (item.end_of_text) begin
         pend_in    = 2'd0;
         partial_in = '0;
         class_in   = CLASS_NONE;
         count_in   = '0;
         ovf_in     = 1'b0;
         failed_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 2'd0;
         partial_ff <= '0;
         class_ff   <= CLASS_NONE;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         failed_ff  <= 1'b0;
      end else if (fire) begin
         pend_ff    <= pend_in;
         partial_ff <= partial_in;
         class_ff   <= class_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

FILE: hw/rtl/utf8vc_out_stage.sv
module utf8vc_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   result_valid,
   input  utf8vc_pkg::result_type result,
   output logic                   advance,
   output logic                   out_valid,
   input  logic                   out_ready,
   output utf8vc_pkg::result_type out_result
);
   import utf8vc_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   // Load when empty or when the waiting item is taken
   assign advance = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = result_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_valid) begin
         result_ff <= result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

FILE: hw/rtl/utf8_validate_and_count.sv
// Streaming strict UTF-8 checker and code point counter.
// A text's result goes from the input register through the decode logic into the result
// register; the per-byte state update is combinational between these registers.
// Throughput: one byte item per cycle while the output is not blocked.
// Reset (synchronous, active high) empties both registers, clears the text state
// and sets max_chars to 1024.
module utf8_validate_and_count (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [utf8vc_pkg::BYTE_WIDTH-1:0]       req_tdata,  // [7:0] text_byte
   input  logic                                    req_tuser,  // [0] byte_present
   input  logic                                    req_tlast,  // end_of_text
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [utf8vc_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,  // [1:0] status, [17:2] char_count
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [utf8vc_pkg::CHARS_WIDTH-1:0]      csr_data
);
   import utf8vc_pkg::*;

   item_type               req_item, item;
   logic                   item_valid, advance, fire, result_valid;
   result_type             result, out_result;
   logic [CHARS_WIDTH-1:0] max_chars_ff;

   assign req_item = '{text_byte: req_tdata, byte_present: req_tuser, end_of_text: req_tlast};

   // Character bound register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
      end else if (csr_valid && csr_ready) begin
         max_chars_ff <= csr_data;
      end
   end

   utf8vc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   assign fire = item_valid && advance;

   utf8vc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (item),
      .max_chars    (max_chars_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   utf8vc_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .advance      (advance),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_result   (out_result)
   );

   // Pack the result item
   assign rsp_tdata = {{(RSP_TDATA_WIDTH - CHARS_WIDTH - 2){1'b0}},
                       out_result.char_count, out_result.status};

   // Invalid and empty texts always report a zero count
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_result.status == ST_INVALID |-> out_result.char_count == '0)
      else $error("invalid result with nonzero count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_result.status == ST_EMPTY |-> out_result.char_count == '0)
      else $error("empty result with nonzero count");

   // Input stalls only when both registers are full and the output is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> item_valid && rsp_tvalid && !rsp_tready)
      else $error("input stalled without a blocked output");

   // A result leaves the core only for an item that ends a text
   a_result_on_end: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> fire && item.end_of_text)
      else $error("result produced for an item that does not end a text");

   // Both registers come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

endmodule
